### sv/rsis_pkg.sv
// ----------------------------------------------------------------------------
// Run state indicator sequencer package
// Shared widths, codes, payload types and time helpers.
// ----------------------------------------------------------------------------
package rsis_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 30;
    localparam int ADDR_W = 3;
    localparam int CNT_W  = $clog2(TIME_W);

    localparam logic [ADDR_W-1:0] REG_FLASH_TICKS   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_BEEP_TICKS    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GREEN_PERIOD  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RED_PERIOD    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_BEEP_ON_SPAN  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_BEEP_OFF_SPAN = 3'd5;

    localparam logic [1:0] MODE_ON   = 2'd0;
    localparam logic [1:0] MODE_STOP = 2'd1;

    typedef struct packed {
        logic [31:0] now_time;
        logic        key_event;
        logic [1:0]  run_mode;
    } in_item_t;

    typedef struct packed {
        logic green_lamp;
        logic red_lamp;
        logic yellow_lamp;
        logic buzzer_drive;
        logic laser_drive;
    } out_item_t;

    // A deadline is reached when now minus deadline is not negative.
    function automatic logic reached(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] tgt);
        logic [TIME_W-1:0] d;
        d = now_t - tgt;
        return !d[TIME_W-1];
    endfunction

    // A zero period counts as one tick; a 30-bit period stays below half the range, so it is never clipped.
    function automatic logic [TIME_W-1:0] eff_period(input logic [CFG_W-1:0] p);
        logic [TIME_W-1:0] pm;
        pm = TIME_W'(p);
        if (pm == '0) begin
            return TIME_W'(1);
        end
        if (pm[TIME_W-1]) begin
            return {1'b0, {(TIME_W-1){1'b1}}};
        end
        return pm;
    endfunction

endpackage

### sv/run_state_indicator_sequencer.sv
// ----------------------------------------------------------------------------
// Run state indicator sequencer
// Drives lamps, buzzer and laser relay from periodic run state polls.
// ----------------------------------------------------------------------------
//   Channel | Ports               | Content
//   poll in | s_valid/s_ready     | s_data: now_time, key_event, run_mode
//   result  | m_valid/m_ready     | m_data: five lamp and relay drives
//   config  | cfg_wr_en/cfg_addr  | cfg_wdata, six 30-bit registers
//
// A poll passes through the prepare and load states, then through the shared remainder
// unit once for each deadline that must be moved forward, and then to its final state.
// Reset is synchronous and restores the register defaults and unarmed timers.
// A new poll is taken while an earlier result still waits in the output
// register; a stalled result holds the sequencer in its final state only.
// ----------------------------------------------------------------------------
module run_state_indicator_sequencer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rsis_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rsis_pkg::out_item_t        m_data,
    input  logic                       cfg_wr_en,
    input  logic [rsis_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [rsis_pkg::CFG_W-1:0]  cfg_wdata
);
    import rsis_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg;

    logic [CFG_W-1:0]  flash_ticks_reg;
    logic [CFG_W-1:0]  beep_ticks_reg;
    logic [CFG_W-1:0]  green_period_reg;
    logic [CFG_W-1:0]  red_period_reg;
    logic [CFG_W-1:0]  beep_on_span_reg;
    logic [CFG_W-1:0]  beep_off_span_reg;

    logic [TIME_W-1:0] now_reg;
    logic              key_reg;
    logic [1:0]        mode_reg;

    logic              flash_live_reg;
    logic              beep_live_reg;
    logic [TIME_W-1:0] flash_end_reg;
    logic [TIME_W-1:0] beep_end_reg;
    logic [TIME_W-1:0] green_next_reg;
    logic [TIME_W-1:0] red_next_reg;
    logic [TIME_W-1:0] cad_next_reg;
    logic              green_lit_reg;
    logic              red_lit_reg;
    logic              cad_on_reg;
    logic              laser_lit_reg;

    logic              pend_g_reg;
    logic              pend_r_reg;
    logic              pend_c_reg;

    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [TIME_W-1:0] job_tgt;
    logic [TIME_W-1:0] job_per;
    logic [TIME_W-1:0] dividend;
    logic [TIME_W-1:0] new_tgt;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_rem;
    logic              any_pend;
    logic              flash_now;
    logic              beep_now;
    logic              out_free;
    logic              s_fire;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign any_pend = pend_g_reg || pend_r_reg || pend_c_reg;
    assign div_start = (state_reg == S_LOAD) && any_pend;

    always_comb begin
        if (pend_g_reg) begin
            job_tgt = green_next_reg;
            job_per = eff_period(green_period_reg);
        end else if (pend_r_reg) begin
            job_tgt = red_next_reg;
            job_per = eff_period(red_period_reg);
        end else begin
            job_tgt = cad_next_reg;
            job_per = eff_period(cad_on_reg ? beep_on_span_reg : beep_off_span_reg);
        end
        dividend  = now_reg - job_tgt;
        new_tgt   = now_reg - div_rem + job_per;
        flash_now = flash_live_reg && !reached(now_reg, flash_end_reg);
        beep_now  = beep_live_reg && !reached(now_reg, beep_end_reg);
    end

    rsis_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (job_per),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_ticks_reg   <= CFG_W'(100);
            beep_ticks_reg    <= CFG_W'(50);
            green_period_reg  <= CFG_W'(500);
            red_period_reg    <= CFG_W'(250);
            beep_on_span_reg  <= CFG_W'(200);
            beep_off_span_reg <= CFG_W'(800);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FLASH_TICKS:   flash_ticks_reg   <= cfg_wdata;
                REG_BEEP_TICKS:    beep_ticks_reg    <= cfg_wdata;
                REG_GREEN_PERIOD:  green_period_reg  <= cfg_wdata;
                REG_RED_PERIOD:    red_period_reg    <= cfg_wdata;
                REG_BEEP_ON_SPAN:  beep_on_span_reg  <= cfg_wdata;
                REG_BEEP_OFF_SPAN: beep_off_span_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            now_reg  <= TIME_W'(s_data.now_time);
            key_reg  <= s_data.key_event;
            mode_reg <= s_data.run_mode;
        end
        if (state_reg == S_FIN && out_free) begin
            m_data_reg.green_lamp   <= green_lit_reg;
            m_data_reg.red_lamp     <= red_lit_reg;
            m_data_reg.yellow_lamp  <= flash_now;
            m_data_reg.buzzer_drive <= cad_on_reg || beep_now;
            m_data_reg.laser_drive  <= laser_lit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            flash_live_reg <= 1'b0;
            beep_live_reg  <= 1'b0;
            flash_end_reg  <= '0;
            beep_end_reg   <= '0;
            green_next_reg <= '0;
            red_next_reg   <= '0;
            cad_next_reg   <= '0;
            green_lit_reg  <= 1'b0;
            red_lit_reg    <= 1'b0;
            cad_on_reg     <= 1'b0;
            laser_lit_reg  <= 1'b0;
            pend_g_reg     <= 1'b0;
            pend_r_reg     <= 1'b0;
            pend_c_reg     <= 1'b0;
        end else begin
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (key_reg) begin
                        flash_live_reg <= 1'b1;
                        flash_end_reg  <= now_reg + TIME_W'(flash_ticks_reg);
                        beep_live_reg  <= 1'b1;
                        beep_end_reg   <= now_reg + TIME_W'(beep_ticks_reg);
                    end
                    laser_lit_reg <= (mode_reg == MODE_ON);
                    if (mode_reg == MODE_ON) begin
                        red_lit_reg <= 1'b0;
                        cad_on_reg  <= 1'b0;
                        if (green_next_reg == '0) begin
                            green_next_reg <= now_reg + eff_period(green_period_reg);
                        end else if (reached(now_reg, green_next_reg)) begin
                            green_lit_reg <= !green_lit_reg;
                            pend_g_reg    <= 1'b1;
                        end
                        red_next_reg <= '0;
                        cad_next_reg <= '0;
                    end else if (mode_reg == MODE_STOP) begin
                        green_lit_reg <= 1'b0;
                        if (red_next_reg == '0) begin
                            red_next_reg <= now_reg + eff_period(red_period_reg);
                        end else if (reached(now_reg, red_next_reg)) begin
                            red_lit_reg <= !red_lit_reg;
                            pend_r_reg  <= 1'b1;
                        end
                        if (cad_next_reg == '0) begin
                            cad_on_reg   <= 1'b1;
                            cad_next_reg <= now_reg + eff_period(beep_on_span_reg);
                        end else if (reached(now_reg, cad_next_reg)) begin
                            cad_on_reg <= !cad_on_reg;
                            pend_c_reg <= 1'b1;
                        end
                        green_next_reg <= '0;
                    end else begin
                        green_lit_reg  <= 1'b0;
                        red_lit_reg    <= 1'b0;
                        cad_on_reg     <= 1'b0;
                        green_next_reg <= '0;
                        red_next_reg   <= '0;
                        cad_next_reg   <= '0;
                    end
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    state_reg <= any_pend ? S_WAIT : S_FIN;
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (pend_g_reg) begin
                            green_next_reg <= new_tgt;
                            pend_g_reg     <= 1'b0;
                        end else if (pend_r_reg) begin
                            red_next_reg <= new_tgt;
                            pend_r_reg   <= 1'b0;
                        end else begin
                            cad_next_reg <= new_tgt;
                            pend_c_reg   <= 1'b0;
                        end
                        state_reg <= S_LOAD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        flash_live_reg <= flash_now;
                        beep_live_reg  <= beep_now;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/rsis_rem_unit.sv
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module rsis_rem_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rsis_pkg::TIME_W-1:0] dividend,
    input  logic [rsis_pkg::TIME_W-1:0] divisor,
    output logic                       done,
    output logic [rsis_pkg::TIME_W-1:0] remainder
);
    import rsis_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] shf_reg;
    logic [TIME_W-1:0] dvs_reg;
    logic [TIME_W:0]   partial;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] rem_next;

    always_comb begin
        partial  = {rem_reg, shf_reg[TIME_W-1]};
        diff     = partial - {1'b0, dvs_reg};
        rem_next = diff[TIME_W] ? partial[TIME_W-1:0] : diff[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TIME_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            shf_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[TIME_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### sv/rsis_check.sv
// ----------------------------------------------------------------------------
// Run state indicator sequencer checker
// Port-level properties of the sequencer, attached to the top level.
// ----------------------------------------------------------------------------
module rsis_check (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input rsis_pkg::out_item_t        m_data
);
    import rsis_pkg::*;

    // A poll transfer keeps the sequencer busy for at least the next cycle.
    a_busy_after_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer ready right after a poll transfer");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // The laser relay is only on in the ON state, where the red lamp is dark.
    a_laser_no_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.laser_drive |-> !m_data.red_lamp)
        else $error("red lamp lit with laser on");

    // The green lamp is only lit in the ON state.
    a_green_needs_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.laser_drive |-> !m_data.green_lamp)
        else $error("green lamp lit outside the ON state");

endmodule

bind run_state_indicator_sequencer rsis_check u_rsis_check (.*);

### dv/run_state_indicator_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Run state indicator sequencer testbench
// Sends timed poll transfers through the sequencer under several register
// settings and checks each lamp and relay result against a local prediction.
// Both channels see random stalls. Directed polls cover time wrap, deadlines
// that land on zero, catch-up, zero settings and the unused run mode.
// Random polls follow a running tick count with noise and backward jumps.
// ----------------------------------------------------------------------------
module run_state_indicator_sequencer_tb;

    import rsis_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    in_item_t            pending_polls[$];
    out_item_t           awaited_drives[$];

    int unsigned         polls_queued  = 0;
    int unsigned         polls_taken   = 0;
    int unsigned         drives_seen   = 0;
    int unsigned         settings_used = 1;
    int unsigned         errors        = 0;
    int unsigned         gap_left      = 0;
    int unsigned         stall_left    = 0;
    logic                in_taken      = 1'b0;
    logic                out_taken     = 1'b0;
    logic                quiet         = 1'b0;
    logic [31:0]         tick          = '0;
    logic [1:0]          cur_mode      = MODE_ON;

    // Local copy of the registers and of the sequencer state.
    logic [CFG_W-1:0]    flash_len, chirp_len, grn_per, red_per, cad_on_len, cad_off_len;
    logic                yel_on, chirp_on, grn_state, red_state, cad_state;
    logic [31:0]         yel_end, chirp_end, grn_due, red_due, cad_due;

    run_state_indicator_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_predictor();
        flash_len   = 30'd100;
        chirp_len   = 30'd50;
        grn_per     = 30'd500;
        red_per     = 30'd250;
        cad_on_len  = 30'd200;
        cad_off_len = 30'd800;
        yel_on      = 1'b0;
        chirp_on    = 1'b0;
        grn_state   = 1'b0;
        red_state   = 1'b0;
        cad_state   = 1'b0;
        yel_end     = '0;
        chirp_end   = '0;
        grn_due     = '0;
        red_due     = '0;
        cad_due     = '0;
    endfunction

    function automatic logic is_due(logic [31:0] now_t, logic [31:0] tgt);
        logic [31:0] diff;
        diff = now_t - tgt;
        return ~diff[31];
    endfunction

    function automatic logic [31:0] period_of(logic [CFG_W-1:0] p);
        return (p == '0) ? 32'd1 : {2'b00, p};
    endfunction

    function automatic logic [31:0] push_past(logic [31:0] now_t, logic [31:0] tgt,
                                              logic [CFG_W-1:0] p);
        logic [31:0] per;
        logic [31:0] diff;
        logic [63:0] steps;
        logic [63:0] sum;
        per   = period_of(p);
        diff  = now_t - tgt;
        steps = {32'd0, diff / per} + 64'd1;
        sum   = {32'd0, tgt} + steps * {32'd0, per};
        return sum[31:0];
    endfunction

    function automatic out_item_t compute_drives(in_item_t poll);
        out_item_t   res;
        logic [31:0] now_t;
        now_t = poll.now_time;
        if (poll.key_event) begin
            yel_on    = 1'b1;
            yel_end   = now_t + {2'b00, flash_len};
            chirp_on  = 1'b1;
            chirp_end = now_t + {2'b00, chirp_len};
        end
        if (poll.run_mode == MODE_ON) begin
            red_state = 1'b0;
            cad_state = 1'b0;
            if (grn_due == '0) begin
                grn_due = now_t + period_of(grn_per);
            end
            if (is_due(now_t, grn_due)) begin
                grn_state = ~grn_state;
                grn_due   = push_past(now_t, grn_due, grn_per);
            end
            red_due = '0;
            cad_due = '0;
        end else if (poll.run_mode == MODE_STOP) begin
            grn_state = 1'b0;
            if (red_due == '0) begin
                red_due = now_t + period_of(red_per);
            end
            if (is_due(now_t, red_due)) begin
                red_state = ~red_state;
                red_due   = push_past(now_t, red_due, red_per);
            end
            if (cad_due == '0) begin
                cad_state = 1'b1;
                cad_due   = now_t + period_of(cad_on_len);
            end else if (is_due(now_t, cad_due)) begin
                cad_state = ~cad_state;
                cad_due   = push_past(now_t, cad_due, cad_state ? cad_on_len : cad_off_len);
            end
            grn_due = '0;
        end else begin
            grn_state = 1'b0;
            red_state = 1'b0;
            cad_state = 1'b0;
            grn_due   = '0;
            red_due   = '0;
            cad_due   = '0;
        end
        if (yel_on && is_due(now_t, yel_end)) begin
            yel_on = 1'b0;
        end
        if (chirp_on && is_due(now_t, chirp_end)) begin
            chirp_on = 1'b0;
        end
        res.green_lamp   = grn_state;
        res.red_lamp     = red_state;
        res.yellow_lamp  = yel_on;
        res.buzzer_drive = cad_state | chirp_on;
        res.laser_drive  = (poll.run_mode == MODE_ON);
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", drives_seen, msg);
        errors++;
    endtask

    task automatic check_field(string field, logic got, logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %b expected %b", field, got, want));
        end
    endtask

    // Poll driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_polls.size() != 0) begin
                s_data   <= pending_polls.pop_front();
                s_valid  <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (out_taken) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Transfer monitor and checker.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken  = 1'b0;
            out_taken = 1'b0;
        end else begin
            out_taken = m_valid && m_ready;
            if (out_taken) begin
                drives_seen++;
                if (awaited_drives.size() == 0) begin
                    report_mismatch("result with no poll waiting");
                end else begin
                    out_item_t want;
                    want = awaited_drives.pop_front();
                    check_field("green_lamp", m_data.green_lamp, want.green_lamp);
                    check_field("red_lamp", m_data.red_lamp, want.red_lamp);
                    check_field("yellow_lamp", m_data.yellow_lamp, want.yellow_lamp);
                    check_field("buzzer_drive", m_data.buzzer_drive, want.buzzer_drive);
                    check_field("laser_drive", m_data.laser_drive, want.laser_drive);
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                awaited_drives.push_back(compute_drives(s_data));
                polls_taken++;
            end
        end
    end

    task automatic add_poll(logic [31:0] now_t, logic key, logic [1:0] mode);
        in_item_t poll;
        poll.now_time  = now_t;
        poll.key_event = key;
        poll.run_mode  = mode;
        pending_polls.push_back(poll);
        polls_queued++;
    endtask

    task automatic wait_idle();
        while (polls_taken != polls_queued || awaited_drives.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FLASH_TICKS:   flash_len   = val;
            REG_BEEP_TICKS:    chirp_len   = val;
            REG_GREEN_PERIOD:  grn_per     = val;
            REG_RED_PERIOD:    red_per     = val;
            REG_BEEP_ON_SPAN:  cad_on_len  = val;
            REG_BEEP_OFF_SPAN: cad_off_len = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] f, logic [CFG_W-1:0] b,
                                  logic [CFG_W-1:0] g, logic [CFG_W-1:0] r,
                                  logic [CFG_W-1:0] on_t, logic [CFG_W-1:0] off_t);
        wait_idle();
        write_reg(REG_FLASH_TICKS, f);
        write_reg(REG_BEEP_TICKS, b);
        write_reg(REG_GREEN_PERIOD, g);
        write_reg(REG_RED_PERIOD, r);
        write_reg(REG_BEEP_ON_SPAN, on_t);
        write_reg(REG_BEEP_OFF_SPAN, off_t);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic add_random_polls(int n, logic [31:0] reach);
        int unsigned r;
        int unsigned m;
        logic        key;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                m = $urandom_range(0, 19);
                cur_mode = (m < 8) ? MODE_ON : (m < 16) ? MODE_STOP :
                           (m < 19) ? MODE_IDLE : MODE_SPARE;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                tick = tick + $urandom_range(0, reach);
            end else if (r < 88) begin
                tick = $urandom();
            end else if (r < 94) begin
                tick = tick - $urandom_range(1, reach);
            end else if (r < 97) begin
                tick = tick + 32'h8000_0000 + $urandom_range(0, reach);
            end else begin
                tick = 32'hFFFF_FFFF - $urandom_range(0, reach);
            end
            key = ($urandom_range(0, 99) < 12);
            add_poll(tick, key, cur_mode);
        end
    endtask

    task automatic random_phase(int n);
        logic [CFG_W-1:0] v[6];
        logic [CFG_W-1:0] top;
        top = '0;
        for (int k = 0; k < 6; k++) begin
            v[k] = CFG_W'($urandom_range(1, 40));
            if (v[k] > top) begin
                top = v[k];
            end
        end
        apply_settings(v[0], v[1], v[2], v[3], v[4], v[5]);
        quiet = ($urandom_range(0, 3) == 0);
        add_random_polls(n, {2'b00, top} * 3);
    endtask

    initial begin
        #2000000;
        $display("run_state_indicator_sequencer regression: fail");
        $finish;
    end

    initial begin
        clear_predictor();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: arming, toggle, catch-up, wrap and mode changes.
        add_poll(32'd0, 1'b1, MODE_ON);
        add_poll(32'd100, 1'b0, MODE_ON);
        add_poll(32'd500, 1'b0, MODE_ON);
        add_poll(32'd2600, 1'b0, MODE_ON);
        add_poll(32'd2600, 1'b0, MODE_STOP);
        add_poll(32'd2850, 1'b0, MODE_STOP);
        add_poll(32'd3100, 1'b1, MODE_STOP);
        add_poll(32'd3200, 1'b1, MODE_IDLE);
        add_poll(32'd3250, 1'b0, MODE_SPARE);
        add_poll(32'hFFFF_FE0C, 1'b0, MODE_ON);
        add_poll(32'hFFFF_FFFF, 1'b0, MODE_ON);
        add_poll(32'd0, 1'b0, MODE_ON);
        add_poll(32'hFFFF_FFFF, 1'b1, MODE_STOP);
        add_poll(32'h7FFF_FFFF, 1'b0, MODE_STOP);
        add_poll(32'h8000_0000, 1'b0, MODE_STOP);

        // Zero settings: one-tick periods and pulses that never show.
        apply_settings('0, '0, '0, '0, '0, '0);
        add_poll(32'd10, 1'b1, MODE_ON);
        add_poll(32'd10, 1'b0, MODE_ON);
        add_poll(32'd11, 1'b0, MODE_ON);
        add_poll(32'd15, 1'b0, MODE_STOP);
        add_poll(32'd15, 1'b1, MODE_STOP);
        add_poll(32'd16, 1'b0, MODE_STOP);
        add_poll(32'd40, 1'b0, MODE_ON);
        tick = 32'd40;
        add_random_polls(60, 32'd4);

        apply_settings(30'd3, 30'd2, 30'd5, 30'd4, 30'd3, 30'd6);
        add_random_polls(150, 32'd18);

        apply_settings(30'd1, 30'd1, 30'd1, 30'd1, 30'd1, 30'd1);
        quiet = 1'b1;
        add_random_polls(80, 32'd4);

        apply_settings('1, '1, '1, '1, '1, '1);
        quiet = 1'b0;
        add_random_polls(80, 32'h7FFF_FFFF);

        random_phase(150);
        random_phase(150);
        random_phase(150);

        apply_settings(30'd7, '1, 30'd9, 30'd2, '1, 30'd1);
        quiet = 1'b0;
        add_random_polls(100, 32'd40);

        wait_idle();
        repeat (100) @(negedge aclk);

        $display("covered %0d poll transfers and %0d result transfers over %0d register settings",
                 polls_taken, drives_seen, settings_used);
        if (errors == 0 && awaited_drives.size() == 0) begin
            $display("run_state_indicator_sequencer regression: pass");
        end else begin
            $display("%0d mismatches, %0d results still awaited", errors, awaited_drives.size());
            $display("run_state_indicator_sequencer regression: fail");
        end
        $finish;
    end

endmodule
